// ----- design/calendar_date_add_days_top_defines.svh -----
// assertion macros for the calendar date add days block
`ifndef CALENDAR_DATE_ADD_DAYS_TOP_DEFINES_SVH
`define CALENDAR_DATE_ADD_DAYS_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define CDAD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define CDAD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/cdad_pkg.sv -----
// shared types, codes and month table for the calendar date add days block
package cdad_pkg;

  localparam int DAY_W    = 5;
  localparam int MONTH_W  = 4;
  localparam int YEAR_W   = 14;
  localparam int OFFSET_W = 16;
  localparam int STATUS_W = 2;
  localparam int CFG_IDX_W = 2;

  typedef logic [DAY_W-1:0]    day_t;
  typedef logic [MONTH_W-1:0]  month_t;
  typedef logic [YEAR_W-1:0]   year_t;
  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam status_t STAT_OK       = 2'd0;
  localparam status_t STAT_BAD_DATE = 2'd1;
  localparam status_t STAT_RANGE    = 2'd2;

  localparam cfg_idx_t CFG_MIN_YEAR = 2'd0;
  localparam cfg_idx_t CFG_MAX_YEAR = 2'd1;

  localparam year_t MIN_YEAR_RST = 14'd1902;
  localparam year_t MAX_YEAR_RST = 14'd2037;
  localparam year_t CENTURY      = 14'd100;
  localparam year_t LAST_IN_CENT = 14'd99;

  localparam month_t JANUARY  = 4'd1;
  localparam month_t FEBRUARY = 4'd2;
  localparam month_t DECEMBER = 4'd12;
  localparam day_t   DEC_DAYS = 5'd31;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_CHECK,
    ST_STEP,
    ST_DONE
  } state_t;

  // month length with the leap day folded in
  function automatic day_t days_in(input month_t m, input logic leap);
    day_t d;
    case (m)
      4'd2:                      d = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   d = 5'd30;
      default:                   d = 5'd31;
    endcase
    return d;
  endfunction

endpackage

// ----- design/cdad_in_if.sv -----
// input item channel: starting date and day offset
interface cdad_in_if;
  logic                              valid;
  logic                              ready;
  cdad_pkg::day_t                    day;
  cdad_pkg::month_t                  month;
  cdad_pkg::year_t                   year;
  logic signed [cdad_pkg::OFFSET_W-1:0] day_offset;

  modport source (output valid, output day, output month, output year,
                  output day_offset, input ready);
  modport sink   (input valid, input day, input month, input year,
                  input day_offset, output ready);
endinterface

// ----- design/cdad_out_if.sv -----
// result item channel: new date and status
interface cdad_out_if;
  logic                valid;
  logic                ready;
  cdad_pkg::day_t      new_day;
  cdad_pkg::month_t    new_month;
  cdad_pkg::year_t     new_year;
  cdad_pkg::status_t   status;

  modport source (output valid, output new_day, output new_month, output new_year,
                  output status, input ready);
  modport sink   (input valid, input new_day, input new_month, input new_year,
                  input status, output ready);
endinterface

// ----- design/calendar_date_add_days_top.sv -----
// top level: date check and one-day-per-cycle stepper for a signed day offset
//
//   channel   | direction | handshake      | payload
//   in_chan   | in        | valid / ready  | day, month, year, day_offset
//   out_chan  | out       | valid / ready  | new_day, new_month, new_year, status
//   cfg       | in        | cfg_we only    | cfg_idx, cfg_wdata (min_year, max_year)
//
// one item at a time: an accept state, year / 100 split by repeated
// subtraction, a check state, stepping through the single day/month/year
// step unit (skipped for a bad date, stopped early by a range error), then
// the result waits in the output register until taken; in_chan.ready is low until then.
// rst_n is synchronous and active low; it restores min_year 1902, max_year 2037.
`include "calendar_date_add_days_top_defines.svh"

module calendar_date_add_days_top (
  input  logic                      clk,
  input  logic                      rst_n,
  cdad_in_if.sink                   in_chan,
  cdad_out_if.source                out_chan,
  input  logic                      cfg_we,
  input  cdad_pkg::cfg_idx_t        cfg_idx,
  input  cdad_pkg::year_t           cfg_wdata
);

  cdad_pkg::state_t  state_r, state_nxt;
  cdad_pkg::year_t   min_year_r, max_year_r;

  cdad_pkg::day_t    d0_r, day_r, day_nxt;
  cdad_pkg::month_t  m0_r, month_r, month_nxt;
  cdad_pkg::year_t   y0_r, year_r, year_nxt;
  cdad_pkg::year_t   rem_r, rem_nxt;
  logic [1:0]        cent_r, cent_nxt;
  logic [cdad_pkg::OFFSET_W-1:0] cnt_r, cnt_nxt;
  logic              back_r, back_nxt;
  cdad_pkg::status_t status_r, status_nxt;

  logic              leap;
  cdad_pkg::day_t    dim_cur;
  cdad_pkg::day_t    dim_prev;
  logic              date_ok;
  logic [cdad_pkg::YEAR_W:0] year_inc;
  logic [cdad_pkg::OFFSET_W:0] off_mag;

  assign leap     = (year_r[1:0] == 2'd0) && ((rem_r != '0) || (cent_r == 2'd0));
  assign dim_cur  = cdad_pkg::days_in(month_r, leap);
  assign dim_prev = cdad_pkg::days_in(month_r - 4'd1, leap);
  assign year_inc = {1'b0, year_r} + 15'd1;
  assign off_mag  = in_chan.day_offset[cdad_pkg::OFFSET_W-1]
                  ? (17'd0 - {in_chan.day_offset[cdad_pkg::OFFSET_W-1],
                              in_chan.day_offset})
                  : {1'b0, in_chan.day_offset};

  always_comb begin
    date_ok = 1'b0;
    if (month_r inside {[cdad_pkg::JANUARY:cdad_pkg::DECEMBER]} &&
        year_r >= min_year_r && year_r <= max_year_r &&
        day_r != '0 && day_r <= dim_cur) begin
      date_ok = 1'b1;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cdad_pkg::ST_IDLE: begin
        if (in_chan.valid) state_nxt = cdad_pkg::ST_DIV;
      end
      cdad_pkg::ST_DIV: begin
        if (rem_r < cdad_pkg::CENTURY) state_nxt = cdad_pkg::ST_CHECK;
      end
      cdad_pkg::ST_CHECK: begin
        state_nxt = date_ok ? cdad_pkg::ST_STEP : cdad_pkg::ST_DONE;
      end
      cdad_pkg::ST_STEP: begin
        if (cnt_r == '0 || status_nxt != cdad_pkg::STAT_OK) state_nxt = cdad_pkg::ST_DONE;
      end
      cdad_pkg::ST_DONE: begin
        if (out_chan.ready) state_nxt = cdad_pkg::ST_IDLE;
      end
      default: state_nxt = cdad_pkg::ST_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    in_chan.ready  = 1'b0;
    out_chan.valid = 1'b0;
    case (state_r)
      cdad_pkg::ST_IDLE: in_chan.ready  = 1'b1;
      cdad_pkg::ST_DONE: out_chan.valid = 1'b1;
      default: ;
    endcase
  end

  // datapath: year split, then one calendar step per cycle
  always_comb begin
    day_nxt    = day_r;
    month_nxt  = month_r;
    year_nxt   = year_r;
    rem_nxt    = rem_r;
    cent_nxt   = cent_r;
    cnt_nxt    = cnt_r;
    back_nxt   = back_r;
    status_nxt = status_r;
    case (state_r)
      cdad_pkg::ST_IDLE: begin
        day_nxt    = in_chan.day;
        month_nxt  = in_chan.month;
        year_nxt   = in_chan.year;
        rem_nxt    = in_chan.year;
        cent_nxt   = 2'd0;
        cnt_nxt    = off_mag[cdad_pkg::OFFSET_W-1:0];
        back_nxt   = in_chan.day_offset[cdad_pkg::OFFSET_W-1];
        status_nxt = cdad_pkg::STAT_OK;
      end
      cdad_pkg::ST_DIV: begin
        if (rem_r >= cdad_pkg::CENTURY) begin
          rem_nxt  = rem_r - cdad_pkg::CENTURY;
          cent_nxt = cent_r + 2'd1;
        end
      end
      cdad_pkg::ST_CHECK: begin
        if (!date_ok) status_nxt = cdad_pkg::STAT_BAD_DATE;
      end
      cdad_pkg::ST_STEP: begin
        if (cnt_r != '0) begin
          cnt_nxt = cnt_r - 16'd1;
          if (!back_r) begin
            if (day_r >= dim_cur) begin
              day_nxt = 5'd1;
              if (month_r == cdad_pkg::DECEMBER) begin
                month_nxt = cdad_pkg::JANUARY;
                year_nxt  = year_inc[cdad_pkg::YEAR_W-1:0];
                if (rem_r == cdad_pkg::LAST_IN_CENT) begin
                  rem_nxt  = '0;
                  cent_nxt = cent_r + 2'd1;
                end else begin
                  rem_nxt = rem_r + 14'd1;
                end
                if (year_inc > {1'b0, max_year_r}) status_nxt = cdad_pkg::STAT_RANGE;
              end else begin
                month_nxt = month_r + 4'd1;
              end
            end else begin
              day_nxt = day_r + 5'd1;
            end
          end else begin
            if (day_r == 5'd1) begin
              if (month_r == cdad_pkg::JANUARY) begin
                if (year_r <= min_year_r) begin
                  status_nxt = cdad_pkg::STAT_RANGE;
                end else begin
                  year_nxt  = year_r - 14'd1;
                  month_nxt = cdad_pkg::DECEMBER;
                  day_nxt   = cdad_pkg::DEC_DAYS;
                  if (rem_r == '0) begin
                    rem_nxt  = cdad_pkg::LAST_IN_CENT;
                    cent_nxt = cent_r - 2'd1;
                  end else begin
                    rem_nxt = rem_r - 14'd1;
                  end
                end
              end else begin
                month_nxt = month_r - 4'd1;
                day_nxt   = dim_prev;
              end
            end else begin
              day_nxt = day_r - 5'd1;
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= cdad_pkg::ST_IDLE;
      min_year_r <= cdad_pkg::MIN_YEAR_RST;
      max_year_r <= cdad_pkg::MAX_YEAR_RST;
      status_r   <= cdad_pkg::STAT_OK;
    end else begin
      state_r  <= state_nxt;
      status_r <= status_nxt;
      if (cfg_we) begin
        case (cfg_idx)
          cdad_pkg::CFG_MIN_YEAR: min_year_r <= cfg_wdata;
          cdad_pkg::CFG_MAX_YEAR: max_year_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == cdad_pkg::ST_IDLE) begin
      d0_r <= in_chan.day;
      m0_r <= in_chan.month;
      y0_r <= in_chan.year;
    end
    day_r   <= day_nxt;
    month_r <= month_nxt;
    year_r  <= year_nxt;
    rem_r   <= rem_nxt;
    cent_r  <= cent_nxt;
    cnt_r   <= cnt_nxt;
    back_r  <= back_nxt;
  end

  // error results echo the starting date
  assign out_chan.status    = status_r;
  assign out_chan.new_day   = (status_r == cdad_pkg::STAT_OK) ? day_r   : d0_r;
  assign out_chan.new_month = (status_r == cdad_pkg::STAT_OK) ? month_r : m0_r;
  assign out_chan.new_year  = (status_r == cdad_pkg::STAT_OK) ? year_r  : y0_r;

  `CDAD_ASSERT_NOW(a_no_overlap, in_chan.ready, !out_chan.valid, "ready while result pending")
  `CDAD_ASSERT_NOW(a_step_date, state_r == cdad_pkg::ST_STEP, (month_r >= cdad_pkg::JANUARY) && (month_r <= cdad_pkg::DECEMBER) && (day_r != 5'd0) && (rem_r < cdad_pkg::CENTURY), "stepper left calendar range")
  `CDAD_ASSERT_NEXT(a_step_end, (state_r == cdad_pkg::ST_STEP) && (cnt_r == '0), state_r == cdad_pkg::ST_DONE, "stepper ran past zero count")

endmodule

// ----- test/date_shift_checker.sv -----
// checker for the date stepper: mirrors the year bounds, predicts each shifted date, compares
`timescale 1ns / 100ps

module date_shift_checker
  import cdad_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     cfg_we,
  input  cfg_idx_t cfg_idx,
  input  year_t    cfg_wdata,
  cdad_in_if       in_mon,
  cdad_out_if      out_mon,
  output int       mismatches,
  output int       pending
);

  typedef struct packed {
    day_t    day;
    month_t  month;
    year_t   year;
    status_t status;
  } shifted_date_t;

  localparam int MONTH_LEN [1:12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  int            lo_year = MIN_YEAR_RST;
  int            hi_year = MAX_YEAR_RST;
  int            err_cnt = 0;
  int            results_seen = 0;
  shifted_date_t expected_dates [$];

  function automatic bit leap_year(int y);
    return (y % 4 == 0) && ((y % 400 == 0) || (y % 100 != 0));
  endfunction

  function automatic int month_days(int m, int y);
    int n;
    n = MONTH_LEN[m];
    if (m == 2 && leap_year(y)) n++;
    return n;
  endfunction

  function automatic shifted_date_t shift_date(day_t d0, month_t m0, year_t y0, int offset,
                                               int lo, int hi);
    shifted_date_t r;
    int            d;
    int            m;
    int            y;
    int            n;
    status_t       st;
    d  = d0;
    m  = m0;
    y  = y0;
    st = STAT_OK;
    if (m < 1 || m > 12 || y < lo || y > hi || d < 1) begin
      st = STAT_BAD_DATE;
    end else if (d > month_days(m, y)) begin
      st = STAT_BAD_DATE;
    end else begin
      for (n = offset; n > 0 && st == STAT_OK; n--) begin
        d++;
        if (d > month_days(m, y)) begin
          d = 1;
          if (m == 12) begin
            m = 1;
            y++;
            if (y > hi) st = STAT_RANGE;
          end else begin
            m++;
          end
        end
      end
      for (n = offset; n < 0 && st == STAT_OK; n++) begin
        d--;
        if (d < 1) begin
          if (m == 1) begin
            if (y <= lo) begin
              st = STAT_RANGE;
            end else begin
              y--;
              m = 12;
            end
          end else begin
            m--;
          end
          if (st == STAT_OK) d = month_days(m, y);
        end
      end
    end
    if (st != STAT_OK) begin
      d = d0;
      m = m0;
      y = y0;
    end
    r.day    = day_t'(d);
    r.month  = month_t'(m);
    r.year   = year_t'(y);
    r.status = st;
    return r;
  endfunction

  always @(posedge clk) begin
    shifted_date_t want;
    shifted_date_t got;
    if (!rst_n) begin
      lo_year = MIN_YEAR_RST;
      hi_year = MAX_YEAR_RST;
      expected_dates.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_MIN_YEAR: lo_year = cfg_wdata;
          CFG_MAX_YEAR: hi_year = cfg_wdata;
          default: ;
        endcase
      end
      if (in_mon.valid === 1'b1 && in_mon.ready === 1'b1) begin
        expected_dates.push_back(shift_date(in_mon.day, in_mon.month, in_mon.year,
                                            int'(in_mon.day_offset), lo_year, hi_year));
      end
      if (out_mon.valid === 1'b1 && out_mon.ready === 1'b1) begin
        got.day    = out_mon.new_day;
        got.month  = out_mon.new_month;
        got.year   = out_mon.new_year;
        got.status = out_mon.status;
        results_seen++;
        if (expected_dates.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10) begin
            $display("result %0d with no item pending: got %0d/%0d/%0d status %0d",
                     results_seen, got.day, got.month, got.year, got.status);
          end
        end else begin
          want = expected_dates.pop_front();
          if (got.day !== want.day || got.month !== want.month ||
              got.year !== want.year || got.status !== want.status) begin
            err_cnt++;
            if (err_cnt <= 10) begin
              $display("result %0d: expected %0d/%0d/%0d status %0d, got %0d/%0d/%0d status %0d",
                       results_seen, want.day, want.month, want.year, want.status,
                       got.day, got.month, got.year, got.status);
            end
          end
        end
      end
    end
    mismatches <= err_cnt;
    pending    <= expected_dates.size();
  end

endmodule

// ----- test/tb_calendar_date_add_days_top.sv -----
// testbench top: drives date items and year bound writes, gives the verdict
`timescale 1ns / 100ps

module tb_calendar_date_add_days_top;
  import cdad_pkg::*;

  localparam cfg_idx_t CFG_SPARE_LO = 2'd2;
  localparam cfg_idx_t CFG_SPARE_HI = 2'd3;
  localparam int       LONG_HOLD    = 300;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     cfg_we    = 1'b0;
  cfg_idx_t cfg_idx   = CFG_MIN_YEAR;
  year_t    cfg_wdata = '0;
  logic     rx_ready  = 1'b0;

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int hold_reqs   = 0;
  int hold_seen   = 0;
  int hold_left   = 0;
  int lo_year     = MIN_YEAR_RST;
  int hi_year     = MAX_YEAR_RST;
  int mismatches;
  int pending;

  cdad_in_if  in_chan ();
  cdad_out_if out_chan ();

  assign out_chan.ready = rx_ready;

  calendar_date_add_days_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  date_shift_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata),
    .in_mon     (in_chan),
    .out_mon    (out_chan),
    .mismatches (mismatches),
    .pending    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side: random stalls plus an occasional long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      rx_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      rx_ready <= 1'b0;
    end else if (hold_seen != hold_reqs) begin
      hold_seen = hold_reqs;
      hold_left = LONG_HOLD;
      rx_ready <= 1'b0;
    end else begin
      rx_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  initial begin
    #200ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic send_date(int d, int m, int y, int offset);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid      <= 1'b1;
    in_chan.day        <= day_t'(d);
    in_chan.month      <= month_t'(m);
    in_chan.year       <= year_t'(y);
    in_chan.day_offset <= 16'(offset);
    @(posedge clk);
    while (in_chan.ready !== 1'b1) @(posedge clk);
  endtask

  // sender stops and waits until every item has its result
  task automatic settle;
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic set_bounds(int lo, int hi);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_MIN_YEAR;
    cfg_wdata <= year_t'(lo);
    @(posedge clk);
    cfg_idx   <= CFG_MAX_YEAR;
    cfg_wdata <= year_t'(hi);
    @(posedge clk);
    // unused index, must leave both bounds alone
    cfg_idx   <= ($urandom_range(1) != 0) ? CFG_SPARE_LO : CFG_SPARE_HI;
    cfg_wdata <= year_t'($urandom_range(9999));
    @(posedge clk);
    cfg_we  <= 1'b0;
    lo_year = lo;
    hi_year = hi;
  endtask

  task automatic send_random;
    int d;
    int m;
    int y;
    int offset;
    int pick;
    pick = $urandom_range(99);
    if (pick < 72 && lo_year <= hi_year) begin
      y = $urandom_range(hi_year, lo_year);
      if ($urandom_range(3) == 0) y = ($urandom_range(1) != 0) ? lo_year : hi_year;
      m = $urandom_range(12, 1);
      d = ($urandom_range(3) == 0) ? $urandom_range(31, 29) : $urandom_range(28, 1);
    end else begin
      d = $urandom_range(31);
      m = $urandom_range(15);
      y = $urandom_range(9999);
    end
    pick = $urandom_range(99);
    if (pick < 3) offset = int'($urandom_range(65535)) - 32768;
    else if (pick < 30) offset = int'($urandom_range(6000)) - 3000;
    else if (pick < 70) offset = int'($urandom_range(800)) - 400;
    else offset = int'($urandom_range(80)) - 40;
    send_date(d, m, y, offset);
  endtask

  initial begin
    int lo;
    in_chan.valid      <= 1'b0;
    in_chan.day        <= '0;
    in_chan.month      <= '0;
    in_chan.year       <= '0;
    in_chan.day_offset <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // reset bounds
    send_date(15, 6, 2000, 0);
    send_date(0, 1, 2000, 1);
    send_date(1, 13, 2000, 5);
    send_date(31, 15, 2037, -1);
    send_date(29, 2, 2000, 1);
    send_date(29, 2, 2001, 0);
    send_date(28, 2, 2003, 1);
    send_date(28, 2, 2004, 1);
    send_date(1, 1, 1901, 0);
    send_date(1, 1, 2038, 0);
    send_date(31, 12, 2036, 1);
    send_date(31, 12, 2037, 1);
    send_date(1, 1, 1903, -1);
    send_date(1, 1, 1902, -1);
    send_date(1, 3, 2000, -1);
    send_date(1, 1, 1902, 32767);
    send_date(31, 12, 2037, -32768);
    settle();

    // bounds 0 to 9999
    set_bounds(0, 9999);
    send_date(29, 2, 1900, 0);
    send_date(29, 2, 2100, 0);
    send_date(29, 2, 1600, 365);
    send_date(1, 1, 0, -1);
    send_date(31, 12, 9999, 1);
    send_date(31, 12, 9999, -32768);
    settle();

    // crossed bounds, then a single valid year
    set_bounds(2000, 1999);
    send_date(15, 6, 2000, 10);
    settle();
    set_bounds(2024, 2024);
    send_date(31, 12, 2024, -365);
    send_date(1, 1, 2024, 366);
    settle();

    tx_idle_pct = 11;
    rx_idle_pct <= 46;
    lo = $urandom_range(3000);
    set_bounds(lo, lo + $urandom_range(9999 - lo));
    repeat (26) send_random();
    settle();

    tx_idle_pct = 46;
    rx_idle_pct <= 11;
    set_bounds(0, 9999);
    repeat (25) send_random();
    settle();

    tx_idle_pct = 0;
    rx_idle_pct <= 0;
    set_bounds(MIN_YEAR_RST, MAX_YEAR_RST);
    hold_reqs <= hold_reqs + 1;
    // short items so a finished result sits behind the hold-off
    send_date(10, 5, 2010, 3);
    send_date(11, 5, 2010, -3);
    repeat (25) send_random();
    settle();

    repeat (400) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
